/* rtl/sha256_hasher_top_macros.svh */
// Assertion macros for the SHA-256 hasher.
// Define ASSERT_OFF to compile the assertions out.
`ifndef SHA256_HASHER_TOP_MACROS_SVH
`define SHA256_HASHER_TOP_MACROS_SVH
`ifndef ASSERT_OFF
// A condition that holds at every clock edge outside reset.
`define SHA_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("assertion failed");
// A condition that implies another one in the next cycle.
`define SHA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SHA_ASSERT(lbl, cond)
`define SHA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* rtl/sha_pkg.sv */
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types, constants and round functions of the SHA-256 hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

  // One queued input beat.
  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       eom;
  } item_t;

  // Control from the sequencer to the round engine.
  typedef struct packed {
    logic start;
    logic init;
  } rnd_ctrl_t;

  // Status of the round engine.
  typedef struct packed {
    logic busy;
    logic step;
    logic done;
  } rnd_stat_t;

  // Control from the sequencer to the message schedule.
  typedef struct packed {
    logic       push;
    logic [7:0] data;
    logic       word_done;
  } sched_ctrl_t;

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  // Byte offset at which the length field begins.
  localparam logic [5:0] LEN_POS = 6'd56;
  localparam logic [7:0] PAD_MARK = 8'h80;

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    ssig0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    ssig1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

endpackage

/* rtl/sha_front.sv */
// ----------------------------------------------------------------------------
// sha_front
// Input queue: takes beats, drops those that carry neither byte nor end mark.
// ----------------------------------------------------------------------------
module sha_front import sha_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  output logic       full_o,
  input  item_t      item_i,
  output logic       valid_o,
  output item_t      item_o,
  input  logic       take_i
);

  item_t       mem_q [4];
  logic [1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [2:0]  cnt_q, cnt_d;
  logic        wr_en, rd_en;

  // Only beats that change the state are queued.
  assign full_o  = (cnt_q == 3'd4);
  assign wr_en   = push_i && !full_o && (item_i.has_byte || item_i.eom);
  assign valid_o = (cnt_q != 3'd0);
  assign rd_en   = take_i && valid_o;
  assign item_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q + 2'd1;
    rd_d  = rd_q + 2'd1;
    cnt_d = cnt_q + {2'b00, wr_en} - {2'b00, rd_en};
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 2'd0;
      rd_q  <= 2'd0;
      cnt_q <= 3'd0;
    end else begin
      if (wr_en) wr_q <= wr_d;
      if (rd_en) rd_q <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_q] <= item_i;
  end

endmodule

/* rtl/sha_sched.sv */
// ----------------------------------------------------------------------------
// sha_sched
// Packs bytes into words and expands the message schedule in a 16-word window.
// ----------------------------------------------------------------------------
module sha_sched import sha_pkg::*; (
  input  logic        clk_i,
  input  sched_ctrl_t ctrl_i,
  input  logic        step_i,
  output logic [31:0] w_o
);

  logic [31:0] win_q [16];
  logic [23:0] acc_q;
  logic [31:0] new_w;

  // Next schedule word from the fixed taps of the window.
  assign new_w = win_q[0] + ssig0(win_q[1]) + win_q[9] + ssig1(win_q[14]);
  assign w_o   = win_q[0];

  // The window shifts on a completed word or on each round.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) acc_q <= {acc_q[15:0], ctrl_i.data};
    if ((ctrl_i.push && ctrl_i.word_done) || step_i) begin
      for (int i = 0; i < 15; i++) win_q[i] <= win_q[i+1];
      win_q[15] <= step_i ? new_w : {acc_q, ctrl_i.data};
    end
  end

endmodule

/* rtl/sha_rounds.sv */
// ----------------------------------------------------------------------------
// sha_rounds
// Chaining words and the 64-round compression, one round per cycle.
// ----------------------------------------------------------------------------
module sha_rounds import sha_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  rnd_ctrl_t   ctrl_i,
  input  logic [31:0] w_i,
  output rnd_stat_t   stat_o,
  output logic [31:0] chain_o [8]
);

  logic [31:0] h_q [8];
  logic [31:0] r_q [8];
  logic [5:0]  cnt_q;
  logic        busy_q, add_q;
  logic [31:0] t1, t2;

  assign t1 = r_q[7] + bsig1(r_q[4]) + ((r_q[4] & r_q[5]) ^ (~r_q[4] & r_q[6]))
            + K[cnt_q] + w_i;
  assign t2 = bsig0(r_q[0]) + ((r_q[0] & r_q[1]) ^ (r_q[0] & r_q[2]) ^ (r_q[1] & r_q[2]));

  assign stat_o.busy = busy_q || add_q;
  assign stat_o.step = busy_q;
  assign stat_o.done = add_q;
  assign chain_o     = h_q;

  // Round counter and phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      add_q  <= 1'b0;
      cnt_q  <= 6'd0;
    end else begin
      add_q <= busy_q && (cnt_q == 6'd63);
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) busy_q <= 1'b0;
      end
    end
  end

  // Chaining words: initial values, then add-back after each block.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q <= IV;
    end else if (ctrl_i.init) begin
      h_q <= IV;
    end else if (add_q) begin
      for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + r_q[i];
    end
  end

  // Working variables.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      r_q <= h_q;
    end else if (busy_q) begin
      r_q[7] <= r_q[6];
      r_q[6] <= r_q[5];
      r_q[5] <= r_q[4];
      r_q[4] <= r_q[3] + t1;
      r_q[3] <= r_q[2];
      r_q[2] <= r_q[1];
      r_q[1] <= r_q[0];
      r_q[0] <= t1 + t2;
    end
  end

endmodule

/* rtl/sha256_hasher_top.sv */
// ----------------------------------------------------------------------------
// sha256_hasher_top
// Streaming SHA-256: bytes in, eight digest words out per message.
// ----------------------------------------------------------------------------
// Each beat carries at most one message byte; a beat with end_of_message set
// closes the message, and eight digest words (index 0 first) follow. A byte
// passes through the sequencer, and each full 64-byte block then goes through
// the round engine (one round per cycle plus add-back). Closing a message
// takes byte-wise padding and one or two compressions. A four-beat input
// queue keeps accepting while the engine works, and a digest buffer holds
// the result while the next message is taken in.
`include "sha256_hasher_top_macros.svh"
module sha256_hasher_top import sha_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic        has_byte_i,
  input  logic        end_of_message_i,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_COMP = 2'd1;
  localparam logic [1:0] ST_PAD  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  item_t       in_item, f_item;
  logic        f_valid, f_take;
  sched_ctrl_t sc;
  rnd_ctrl_t   rc;
  rnd_stat_t   rs;
  logic [31:0] w_cur;
  logic [31:0] chain [8];

  logic [1:0]  state_q, state_d;
  logic [5:0]  fill_q, fill_d;
  logic [60:0] total_q, total_d;
  logic [63:0] len_q, len_d;
  logic        eom_q, eom_d, pad_q, pad_d, mark_q, mark_d;
  logic        lenok_q, lenok_d, fin_q, fin_d;
  logic [31:0] dig_q [8];
  logic [2:0]  idx_q;
  logic        ovalid_q, dig_load;

  assign in_item = '{data: data_byte_i, has_byte: has_byte_i, eom: end_of_message_i};

  sha_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (full),
    .item_i  (in_item),
    .valid_o (f_valid),
    .item_o  (f_item),
    .take_i  (f_take)
  );

  sha_sched u_sched (
    .clk_i  (clk_i),
    .ctrl_i (sc),
    .step_i (rs.step),
    .w_o    (w_cur)
  );

  sha_rounds u_rounds (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (rc),
    .w_i     (w_cur),
    .stat_o  (rs),
    .chain_o (chain)
  );

  // Sequencer: byte intake, padding and digest hand-over.
  always_comb begin
    state_d  = state_q;
    fill_d   = fill_q;
    total_d  = total_q;
    len_d    = len_q;
    eom_d    = eom_q;
    pad_d    = pad_q;
    mark_d   = mark_q;
    lenok_d  = lenok_q;
    fin_d    = fin_q;
    f_take   = 1'b0;
    sc       = '{push: 1'b0, data: 8'h00, word_done: (fill_q[1:0] == 2'd3)};
    rc       = '{start: 1'b0, init: 1'b0};
    dig_load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (f_valid) begin
          f_take = 1'b1;
          if (f_item.has_byte) begin
            sc.push = 1'b1;
            sc.data = f_item.data;
            fill_d  = fill_q + 6'd1;
            total_d = total_q + 61'd1;
          end
          if (f_item.has_byte && fill_q == 6'd63) begin
            rc.start = 1'b1;
            eom_d    = f_item.eom;
            state_d  = ST_COMP;
          end else if (f_item.eom) begin
            pad_d   = 1'b1;
            state_d = ST_PAD;
          end
        end
      end
      ST_COMP: begin
        if (rs.done) begin
          if (fin_q) begin
            state_d = ST_DONE;
          end else if (pad_q) begin
            lenok_d = 1'b1;
            state_d = ST_PAD;
          end else if (eom_q) begin
            eom_d   = 1'b0;
            pad_d   = 1'b1;
            state_d = ST_PAD;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_PAD: begin
        sc.push = 1'b1;
        fill_d  = fill_q + 6'd1;
        if (!mark_q) begin
          sc.data = PAD_MARK;
          mark_d  = 1'b1;
          len_d   = {total_q, 3'b000};
          lenok_d = (fill_q < LEN_POS);
        end else if (lenok_q && fill_q >= LEN_POS) begin
          sc.data = len_q[63:56];
          len_d   = {len_q[55:0], 8'h00};
        end
        if (fill_q == 6'd63) begin
          rc.start = 1'b1;
          fin_d    = lenok_q;
          state_d  = ST_COMP;
        end
      end
      ST_DONE: begin
        if (!ovalid_q) begin
          dig_load = 1'b1;
          rc.init  = 1'b1;
          fill_d   = 6'd0;
          total_d  = 61'd0;
          pad_d    = 1'b0;
          mark_d   = 1'b0;
          lenok_d  = 1'b0;
          fin_d    = 1'b0;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= 6'd0;
      total_q <= 61'd0;
      eom_q   <= 1'b0;
      pad_q   <= 1'b0;
      mark_q  <= 1'b0;
      lenok_q <= 1'b0;
      fin_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      total_q <= total_d;
      eom_q   <= eom_d;
      pad_q   <= pad_d;
      mark_q  <= mark_d;
      lenok_q <= lenok_d;
      fin_q   <= fin_d;
    end
  end

  // Length shift register.
  always_ff @(posedge clk_i) begin
    len_q <= len_d;
  end

  // Digest buffer and word counter on the result side.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
      idx_q    <= 3'd0;
    end else if (dig_load) begin
      ovalid_q <= 1'b1;
      idx_q    <= 3'd0;
    end else if (pop && ovalid_q) begin
      idx_q <= idx_q + 3'd1;
      if (idx_q == 3'd7) ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dig_load) dig_q <= chain;
  end

  assign empty         = !ovalid_q;
  assign digest_word_o = dig_q[idx_q];
  assign word_index_o  = idx_q;
  assign last_word_o   = (idx_q == 3'd7);

  // The round engine only runs while the sequencer waits for it.
  `SHA_ASSERT(a_busy_in_comp, !rs.busy || state_q == ST_COMP)
  // A digest is shown from its first word.
  `SHA_ASSERT(a_idx_when_idle, empty || word_index_o == 3'd0 || !$rose(!empty))
  // Taking the last word leaves the counter at the first word.
  `SHA_ASSERT_NEXT(a_last_wraps, pop && !empty && last_word_o, word_index_o == 3'd0)

endmodule
